[hdl/qri_pkg.sv]
// Shared types and constants for the QR iteration eigenvalue block.
// Used by qri_unit and qr_iteration_eigenvalues_top; depends on nothing.
package qri_pkg;

  localparam int MAX_ORDER = 16;
  localparam int IDX_W     = 4;
  localparam int ADDR_W    = 2 * IDX_W;
  localparam int CELLS     = MAX_ORDER * MAX_ORDER;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = 1'd1;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_RUN   = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic [3:0]        row_index;
    logic [3:0]        col_index;
    logic signed [31:0] element_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] eigenvalue;
    logic [3:0]        eigen_index;
    logic              last_result;
    logic              singular_seen;
  } out_item_t;

  typedef struct packed {
    logic        start;
    logic        root;
    logic [63:0] arg;
    logic [31:0] divisor;
  } unit_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] value;
  } unit_rsp_t;

endpackage

[hdl/qri_unit.sv]
// Bit-serial integer square root (32 steps) and restoring divider (48 steps).
// Depends on qri_pkg for the request and response types.
module qri_unit
  import qri_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  logic        busy_q, busy_d;
  logic        root_q, root_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [63:0] rem_q, rem_d;
  logic [63:0] res_q, res_d;
  logic [63:0] bit_q, bit_d;
  logic [47:0] num_q, num_d;
  logic [31:0] div_q, div_d;
  logic        done_q, done_d;

  logic [63:0] trial;
  logic [32:0] shifted;

  always_comb begin
    busy_d  = busy_q;
    root_d  = root_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    res_d   = res_q;
    bit_d   = bit_q;
    num_d   = num_q;
    div_d   = div_q;
    done_d  = 1'b0;
    trial   = res_q + bit_q;
    shifted = {rem_q[31:0], num_q[47]};
    if (req_i.start) begin
      busy_d = 1'b1;
      root_d = req_i.root;
      rem_d  = req_i.root ? req_i.arg : 64'd0;
      res_d  = 64'd0;
      bit_d  = 64'd1 << 62;
      num_d  = req_i.arg[47:0];
      div_d  = req_i.divisor;
      cnt_d  = req_i.root ? 6'd31 : 6'd47;
    end else if (busy_q) begin
      if (root_q) begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end else begin
        num_d = {num_q[46:0], 1'b0};
        if (shifted >= {1'b0, div_q}) begin
          rem_d = {32'd0, 32'(shifted - {1'b0, div_q})};
          res_d = {res_q[62:0], 1'b1};
        end else begin
          rem_d = {32'd0, shifted[31:0]};
          res_d = {res_q[62:0], 1'b0};
        end
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 6'd0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    root_q <= root_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    num_q  <= num_d;
    div_q  <= div_d;
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q[47:0];

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("unit started while busy");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("done while busy");
  a_done_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("done without work");

endmodule

[hdl/qr_iteration_eigenvalues_top.sv]
// Top level of the unshifted QR iteration eigenvalue estimator.
// Depends on qri_pkg and qri_unit.
//
// Clear and element-write items transfer one per cycle while idle. A run item
// copies the 256-entry store, then runs iteration_count rounds on one shared
// 32x32 multiplier and one shared root/divide unit: each dot or norm element
// passes through read, multiply and accumulate states, each row norm waits on
// the square root, and each normalized element on the divider. Results then
// follow one at a time; input stalls for the whole run.
module qr_iteration_eigenvalues_top
  import qri_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_data_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE, S_CP_RD, S_CP_WR, S_QI_RD, S_QI_WR,
    S_NRM_RD, S_NRM_MUL, S_NRM_ACC, S_SQ_GO, S_SQ_WT,
    S_ZR_WR, S_DV_RD, S_DV_GO, S_DV_WT, S_RII_WR,
    S_DT_RD, S_DT_MUL, S_DT_ACC, S_DT_FIN,
    S_UP_RD, S_UP_MUL, S_UP_SUB,
    S_RC_RD, S_RC_MUL, S_RC_ACC, S_RC_WR,
    S_EM_RD, S_EM_LD, S_EM_WT
  } state_e;

  state_e           state_q;
  logic [4:0]       msize_q;
  logic [9:0]       iter_q;
  logic [9:0]       rnd_q;
  logic [IDX_W-1:0] i_q, j_q, k_q, nm1_q;
  logic [ADDR_W-1:0] c_q;
  logic             sing_q;
  logic             neg_q;
  logic [31:0]      norm_q;
  logic signed [31:0] rii_q, d_q;
  logic signed [63:0] acc_q, mul_q;
  logic [63:0]      sq_q;
  logic             out_valid_q;
  out_item_t        out_q;

  logic signed [31:0] ld_mem [CELLS];
  logic [CELLS-1:0]   ld_vld_q;
  logic signed [31:0] w_mem [CELLS];
  logic signed [31:0] q_mem [CELLS];
  logic signed [31:0] r_mem [CELLS];
  logic signed [31:0] ld_rd_q, w_rd_q, qa_rd_q, qb_rd_q, r_rd_q;

  logic [ADDR_W-1:0] w_raddr, w_waddr, q_waddr, r_waddr;
  logic              w_we, q_we, r_we;
  logic signed [31:0] w_wdata, q_wdata, r_wdata;

  unit_req_t ureq;
  unit_rsp_t ursp;

  logic signed [31:0] mul_a, mul_b;
  logic signed [64:0] sum65;
  logic signed [63:0] acc_next;
  logic [64:0]        usum;
  logic signed [31:0] dot_res, qm, upd, qdiv_res;
  logic signed [32:0] diff;
  logic [31:0]        mag;
  logic               k_last;
  logic [4:0]         n_eff;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (v < -64'sh80000000) return 32'sh80000000;
    return v[31:0];
  endfunction

  qri_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ureq),
    .rsp_o  (ursp)
  );

  assign k_last = (k_q == nm1_q);
  assign n_eff  = (msize_q == 5'd0) ? 5'd1 :
                  (msize_q > 5'(MAX_ORDER)) ? 5'(MAX_ORDER) : msize_q;

  always_comb begin
    mul_a = qa_rd_q;
    mul_b = qa_rd_q;
    case (state_q)
      S_DT_MUL: mul_b = qb_rd_q;
      S_UP_MUL: mul_a = d_q;
      S_RC_MUL: begin
        mul_a = (k_q < i_q) ? 32'sd0 : r_rd_q;
        mul_b = qb_rd_q;
      end
      default: ;
    endcase
  end

  assign sum65    = {acc_q[63], acc_q} + {mul_q[63], mul_q};
  assign acc_next = (k_q == '0) ? mul_q :
                    (sum65[64] != sum65[63]) ?
                    (sum65[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : sum65[63:0];
  assign usum     = {1'b0, sq_q} + {1'b0, mul_q};
  assign dot_res  = sat32(acc_q >>> 16);
  assign qm       = sat32(mul_q >>> 16);
  assign diff     = {qb_rd_q[31], qb_rd_q} - {qm[31], qm};
  assign upd      = sat32(64'(diff));
  assign mag      = qa_rd_q[31] ? 32'(~qa_rd_q + 32'sd1) : 32'(qa_rd_q);

  always_comb begin
    if (neg_q) begin
      qdiv_res = (ursp.value > 48'h80000000) ? 32'sh80000000 : 32'(-ursp.value);
    end else begin
      qdiv_res = (ursp.value > 48'h7FFFFFFF) ? 32'sh7FFFFFFF : 32'(ursp.value);
    end
  end

  always_comb begin
    ureq.start   = (state_q == S_SQ_GO) || (state_q == S_DV_GO);
    ureq.root    = (state_q == S_SQ_GO);
    ureq.arg     = (state_q == S_SQ_GO) ? sq_q : {16'd0, mag, 16'd0};
    ureq.divisor = norm_q;
  end

  always_comb begin
    w_raddr = (state_q == S_EM_RD) ? {i_q, i_q} : {i_q, k_q};
    w_we    = (state_q == S_CP_WR) || (state_q == S_RC_WR);
    w_waddr = (state_q == S_CP_WR) ? c_q : {j_q, i_q};
    w_wdata = (state_q == S_CP_WR) ? ld_rd_q : dot_res;
    q_we    = 1'b0;
    q_waddr = {i_q, k_q};
    q_wdata = w_rd_q;
    r_we    = 1'b0;
    r_waddr = {i_q, i_q};
    r_wdata = rii_q;
    case (state_q)
      S_QI_WR: q_we = 1'b1;
      S_ZR_WR: begin
        q_we    = 1'b1;
        q_wdata = 32'sd0;
      end
      S_DV_WT: begin
        q_we    = ursp.done;
        q_wdata = qdiv_res;
      end
      S_UP_SUB: begin
        q_we    = 1'b1;
        q_waddr = {j_q, k_q};
        q_wdata = upd;
      end
      S_RII_WR: r_we = 1'b1;
      S_DT_FIN: begin
        r_we    = 1'b1;
        r_waddr = {i_q, j_q};
        r_wdata = dot_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o && in_data_i.mode == MODE_WRITE) begin
      ld_mem[{in_data_i.row_index, in_data_i.col_index}] <= in_data_i.element_value;
    end
    ld_rd_q <= ld_vld_q[c_q] ? ld_mem[c_q] : 32'sd0;
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rd_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    qa_rd_q <= q_mem[{i_q, k_q}];
    qb_rd_q <= q_mem[{j_q, k_q}];
  end

  always_ff @(posedge clk_i) begin
    if (r_we) r_mem[r_waddr] <= r_wdata;
    r_rd_q <= r_mem[{i_q, k_q}];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_vld_q <= '0;
    end else if (in_valid_i && !in_stall_o) begin
      if (in_data_i.mode == MODE_CLEAR) begin
        ld_vld_q <= '0;
      end else if (in_data_i.mode == MODE_WRITE) begin
        ld_vld_q[{in_data_i.row_index, in_data_i.col_index}] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      msize_q <= 5'd16;
      iter_q  <= 10'd10;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MATRIX_SIZE:     msize_q <= cfg_data_i[4:0];
        REG_ITERATION_COUNT: iter_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      sing_q      <= 1'b0;
      rnd_q       <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      c_q         <= '0;
      nm1_q       <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_data_i.mode == MODE_RUN) begin
            nm1_q   <= 4'(n_eff - 5'd1);
            sing_q  <= 1'b0;
            rnd_q   <= '0;
            c_q     <= '0;
            state_q <= S_CP_RD;
          end
        end
        S_CP_RD: state_q <= S_CP_WR;
        S_CP_WR: begin
          c_q <= c_q + 1'b1;
          if (c_q == ADDR_W'(CELLS - 1)) begin
            i_q     <= '0;
            k_q     <= '0;
            state_q <= (iter_q == '0) ? S_EM_RD : S_QI_RD;
          end else begin
            state_q <= S_CP_RD;
          end
        end
        S_QI_RD: state_q <= S_QI_WR;
        S_QI_WR: begin
          if (k_last) begin
            k_q <= '0;
            if (i_q == nm1_q) begin
              i_q     <= '0;
              state_q <= S_NRM_RD;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_QI_RD;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_QI_RD;
          end
        end
        S_NRM_RD:  state_q <= S_NRM_MUL;
        S_NRM_MUL: state_q <= S_NRM_ACC;
        S_NRM_ACC: begin
          sq_q <= (k_q == '0) ? mul_q : (usum[64] ? '1 : usum[63:0]);
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_SQ_GO;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_NRM_RD;
          end
        end
        S_SQ_GO: state_q <= S_SQ_WT;
        S_SQ_WT: begin
          if (ursp.done) begin
            norm_q <= ursp.value[31:0];
            if (ursp.value[31:0] == 32'd0) begin
              sing_q  <= 1'b1;
              rii_q   <= 32'sd0;
              state_q <= S_ZR_WR;
            end else begin
              rii_q   <= ursp.value[31] ? 32'sh7FFFFFFF : ursp.value[31:0];
              state_q <= S_DV_RD;
            end
          end
        end
        S_ZR_WR: begin
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_RII_WR;
          end else begin
            k_q <= k_q + 1'b1;
          end
        end
        S_DV_RD: state_q <= S_DV_GO;
        S_DV_GO: begin
          neg_q   <= qa_rd_q[31];
          state_q <= S_DV_WT;
        end
        S_DV_WT: begin
          if (ursp.done) begin
            if (k_last) begin
              k_q     <= '0;
              state_q <= S_RII_WR;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_DV_RD;
            end
          end
        end
        S_RII_WR: begin
          k_q <= '0;
          if (i_q == nm1_q) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= S_RC_RD;
          end else begin
            j_q     <= i_q + 1'b1;
            state_q <= S_DT_RD;
          end
        end
        S_DT_RD:  state_q <= S_DT_MUL;
        S_DT_MUL: state_q <= S_DT_ACC;
        S_DT_ACC: begin
          acc_q <= acc_next;
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_DT_FIN;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_DT_RD;
          end
        end
        S_DT_FIN: begin
          d_q     <= dot_res;
          state_q <= S_UP_RD;
        end
        S_UP_RD:  state_q <= S_UP_MUL;
        S_UP_MUL: state_q <= S_UP_SUB;
        S_UP_SUB: begin
          if (k_last) begin
            k_q <= '0;
            if (j_q == nm1_q) begin
              i_q     <= i_q + 1'b1;
              state_q <= S_NRM_RD;
            end else begin
              j_q     <= j_q + 1'b1;
              state_q <= S_DT_RD;
            end
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_UP_RD;
          end
        end
        S_RC_RD:  state_q <= S_RC_MUL;
        S_RC_MUL: state_q <= S_RC_ACC;
        S_RC_ACC: begin
          acc_q <= acc_next;
          if (k_last) begin
            k_q     <= '0;
            state_q <= S_RC_WR;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RC_RD;
          end
        end
        S_RC_WR: begin
          state_q <= S_RC_RD;
          if (i_q == nm1_q) begin
            i_q <= '0;
            if (j_q == nm1_q) begin
              j_q <= '0;
              if (rnd_q == iter_q - 10'd1) begin
                state_q <= S_EM_RD;
              end else begin
                rnd_q   <= rnd_q + 10'd1;
                state_q <= S_QI_RD;
              end
            end else begin
              j_q <= j_q + 1'b1;
            end
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        S_EM_RD: state_q <= S_EM_LD;
        S_EM_LD: begin
          out_q.eigenvalue    <= w_rd_q;
          out_q.eigen_index   <= i_q;
          out_q.last_result   <= (i_q == nm1_q);
          out_q.singular_seen <= sing_q;
          out_valid_q         <= 1'b1;
          state_q             <= S_EM_WT;
        end
        S_EM_WT: begin
          if (!out_stall_i) begin
            out_valid_q <= 1'b0;
            if (i_q == nm1_q) begin
              state_q <= S_IDLE;
            end else begin
              i_q     <= i_q + 1'b1;
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_out_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == S_EM_WT) else $error("result outside emit");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_data_o.last_result) |=> state_q == S_IDLE)
    else $error("run did not end on last result");
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_data_i.mode == MODE_RUN) |=> in_stall_o)
    else $error("run transfer did not stall input");
  a_unit_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ursp.done |-> (state_q == S_SQ_WT || state_q == S_DV_WT))
    else $error("unit result unclaimed");

endmodule
